FILE: src/fbc_pkg.sv
`timescale 1ns / 1ps

package fbc_pkg;

  // Chunk geometry in world units; positions are Q.8.
  localparam int CHUNK_LENGTH = 16;
  localparam int CHUNK_HEIGHT = 256;
  localparam int LEN_Q  = CHUNK_LENGTH * 256;
  localparam int HALF_Q = CHUNK_LENGTH * 128;
  localparam int HGT_Q  = CHUNK_HEIGHT * 256;

  // Configuration port.
  localparam int CFG_W = 63;
  localparam int IDX_W = 4;

  // Internal datapath widths.
  localparam int NW = 56;      // plane normals
  localparam int NH = NW / 2;  // normal split for partial products
  localparam int PW = 52;      // partial products
  localparam int SW = 96;      // side plane distances
  localparam int FW = 72;      // near and far plane distances

  typedef enum logic [IDX_W-1:0] {
    REG_CAM_POS = 4'd0,
    REG_FRONT   = 4'd1,
    REG_UP      = 4'd2,
    REG_RIGHT   = 4'd3,
    REG_NEAR    = 4'd4,
    REG_FAR     = 4'd5,
    REG_TAN     = 4'd6,
    REG_ASPECT  = 4'd7
  } cfg_reg_e;

endpackage

FILE: src/frustum_box_cull_top.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Direction  Transfer when
// command   start_i, busy_o, chunk_x_i, chunk_z_i   in         start_i high, busy_o low
// result    valid_o, visible_o                      out        valid_o high (one cycle)
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i        in         cfg_we_i high
//
// One chunk is taken every cycle; busy_o never rises. Each result follows its
// command through the eight register stages of the plane product and sum
// pipeline. Reset clears the valid pipeline and loads the default camera.
// The receiver cannot stall, so no stage ever holds.
module frustum_box_cull_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [15:0]           chunk_x_i,
  input  logic signed [15:0]           chunk_z_i,
  output logic                         valid_o,
  output logic                         visible_o,
  input  logic                         cfg_we_i,
  input  logic [fbc_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [fbc_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import fbc_pkg::*;

  function automatic logic signed [65:0] smul(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    return a * b;
  endfunction

  function automatic logic signed [32:0] xc(input logic signed [15:0] a,
                                            input logic signed [15:0] b,
                                            input logic signed [15:0] c,
                                            input logic signed [15:0] d);
    return 33'(smul(a, b) - smul(c, d));
  endfunction

  function automatic logic signed [32:0] nlo(input logic signed [NW-1:0] n);
    return $signed({{(33-NH){1'b0}}, n[NH-1:0]});
  endfunction

  function automatic logic signed [32:0] nhi(input logic signed [NW-1:0] n);
    logic signed [NW-NH-1:0] h;
    h = n[NW-1:NH];
    return h;
  endfunction

  function automatic logic signed [SW-1:0] posw(input logic signed [NW-1:0] x);
    logic signed [SW-1:0] r;
    r = x;
    if (x < 0) r = '0;
    return r;
  endfunction

  function automatic logic signed [FW-1:0] posf(input logic signed [15:0] x);
    logic signed [FW-1:0] r;
    r = x;
    if (x < 0) r = '0;
    return r;
  endfunction

  function automatic logic signed [FW-1:0] negf(input logic signed [15:0] x);
    logic signed [FW-1:0] r;
    r = x;
    if (x > 0) r = '0;
    return r;
  endfunction

  // Camera registers.
  logic [62:0] cam_q;
  logic [47:0] front_q, up_q, right_q;
  logic [23:0] near_q, far_q;
  logic [15:0] tan_q, aspect_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q    <= '0;
      front_q  <= 48'd49152;
      up_q     <= 48'd1073741824;
      right_q  <= 48'd16384;
      near_q   <= 24'd26;
      far_q    <= 24'd256000;
      tan_q    <= 16'd6786;
      aspect_q <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CAM_POS: cam_q    <= cfg_wdata_i;
        REG_FRONT:   front_q  <= cfg_wdata_i[47:0];
        REG_UP:      up_q     <= cfg_wdata_i[47:0];
        REG_RIGHT:   right_q  <= cfg_wdata_i[47:0];
        REG_NEAR:    near_q   <= cfg_wdata_i[23:0];
        REG_FAR:     far_q    <= cfg_wdata_i[23:0];
        REG_TAN:     tan_q    <= cfg_wdata_i[15:0];
        REG_ASPECT:  aspect_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic signed [20:0] cam [3];
  logic signed [15:0] fr [3], up [3], rt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cam[i] = cam_q[21*i +: 21];
      fr[i]  = front_q[16*i +: 16];
      up[i]  = up_q[16*i +: 16];
      rt[i]  = right_q[16*i +: 16];
    end
  end

  // Camera-derived values. The registers load every cycle; the user must not
  // change the camera while chunks are in flight (the block does not enforce
  // this), so that each stage is settled by the time a chunk reaches it.
  logic signed [32:0]   fu_q [3], rf_q [3], ru_q [3];
  logic [31:0]          tqa_q, ff_q, ha_sum;
  logic [19:0]          ha_q;
  logic [55:0]          ndff_q, fdff_q;
  logic signed [NW-1:0] p_q [3], q_q [3];
  logic signed [NW-1:0] n_q [4][3];
  logic signed [SW-1:0] e_q [4];

  assign ha_sum = tqa_q + 32'd2048;

  always_ff @(posedge clk_i) begin
    fu_q[0] <= xc(fr[1], up[2], fr[2], up[1]);
    fu_q[1] <= xc(fr[2], up[0], fr[0], up[2]);
    fu_q[2] <= xc(fr[0], up[1], fr[1], up[0]);
    rf_q[0] <= xc(rt[1], fr[2], rt[2], fr[1]);
    rf_q[1] <= xc(rt[2], fr[0], rt[0], fr[2]);
    rf_q[2] <= xc(rt[0], fr[1], rt[1], fr[0]);
    ru_q[0] <= xc(rt[1], up[2], rt[2], up[1]);
    ru_q[1] <= xc(rt[2], up[0], rt[0], up[2]);
    ru_q[2] <= xc(rt[0], up[1], rt[1], up[0]);
    tqa_q   <= tan_q * aspect_q;
    ff_q    <= 32'(smul(fr[0], fr[0]) + smul(fr[1], fr[1]) + smul(fr[2], fr[2]));

    ha_q    <= ha_sum[31:12];
    ndff_q  <= near_q * ff_q;
    fdff_q  <= far_q * ff_q;

    for (int i = 0; i < 3; i++) begin
      p_q[i] <= NW'(smul($signed({1'b0, ha_q}), ru_q[i]));
      q_q[i] <= NW'(smul($signed({1'b0, tan_q}), ru_q[i]));
      // Right, left, top and bottom normals with the far scale factored out.
      n_q[0][i] <= (NW'(fu_q[i]) <<< 14) - p_q[i];
      n_q[1][i] <= -(NW'(fu_q[i]) <<< 14) - p_q[i];
      n_q[2][i] <= (NW'(rf_q[i]) <<< 14) - q_q[i];
      n_q[3][i] <= -(NW'(rf_q[i]) <<< 14) - q_q[i];
    end

    // Largest corner offset from the low corner along each normal.
    for (int p = 0; p < 4; p++) begin
      e_q[p] <= posw(n_q[p][0]) * LEN_Q + posw(n_q[p][1]) * HGT_Q
              + posw(n_q[p][2]) * LEN_Q;
    end
  end

  // Chunk pipeline.
  logic [7:0]             v_q;
  logic signed [15:0]     cx_q [4], cz_q [4];
  logic signed [31:0]     fcx_q, fcz_q;
  logic signed [36:0]     fcam_q [3];
  logic signed [FW-1:0]   dmax_q, dmin_q, base_f, dmax_d, dmin_d, ndffs, fdffs;
  logic [3:0]             nf_q;
  logic signed [PW-1:0]   pxl_q [4], pxh_q [4], pzl_q [4], pzh_q [4];
  logic signed [PW-1:0]   pcl_q [4][3], pch_q [4][3];
  logic signed [SW-1:0]   ncx_q [4], ncz_q [4], ncam_q [4][3];
  logic signed [SW-1:0]   sa_q [4], sb_q [4];
  logic                   side_cull;

  assign busy_o  = 1'b0;
  assign valid_o = v_q[7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:0], start_i && !busy_o};
    end
  end

  always_comb begin
    base_f = FW'(fcx_q) * LEN_Q - FW'(fr[0]) * HALF_Q
           + FW'(fcz_q) * LEN_Q - FW'(fr[2]) * HALF_Q
           - FW'(fcam_q[0]) - FW'(fcam_q[1]) - FW'(fcam_q[2]);
    dmax_d = base_f + posf(fr[0]) * LEN_Q + posf(fr[1]) * HGT_Q + posf(fr[2]) * LEN_Q;
    dmin_d = base_f + negf(fr[0]) * LEN_Q + negf(fr[1]) * HGT_Q + negf(fr[2]) * LEN_Q;
    ndffs  = $signed(FW'(ndff_q));
    fdffs  = $signed(FW'(fdff_q));
  end

  always_comb begin
    side_cull = 1'b0;
    for (int p = 0; p < 4; p++) begin
      if (sa_q[p] - sb_q[p] < 0) side_cull = 1'b1;
    end
    // With a zero far distance the side planes never cull.
    if (far_q == '0) side_cull = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    cx_q[0] <= chunk_x_i;
    cz_q[0] <= chunk_z_i;
    for (int k = 1; k < 4; k++) begin
      cx_q[k] <= cx_q[k-1];
      cz_q[k] <= cz_q[k-1];
    end

    // Near and far planes: only the front vector matters.
    fcx_q <= 32'(smul(fr[0], cx_q[0]));
    fcz_q <= 32'(smul(fr[2], cz_q[0]));
    for (int i = 0; i < 3; i++) begin
      fcam_q[i] <= 37'(smul(fr[i], cam[i]));
    end
    dmax_q <= dmax_d;
    dmin_q <= dmin_d;
    nf_q[0] <= ((dmax_q <<< 14) - ndffs < 0) || ((dmin_q <<< 14) - fdffs > 0);
    nf_q[3:1] <= nf_q[2:0];

    // Side planes: split each normal so every product stays narrow.
    for (int p = 0; p < 4; p++) begin
      pxl_q[p] <= PW'(smul(nlo(n_q[p][0]), cx_q[3]));
      pxh_q[p] <= PW'(smul(nhi(n_q[p][0]), cx_q[3]));
      pzl_q[p] <= PW'(smul(nlo(n_q[p][2]), cz_q[3]));
      pzh_q[p] <= PW'(smul(nhi(n_q[p][2]), cz_q[3]));
      for (int i = 0; i < 3; i++) begin
        pcl_q[p][i] <= PW'(smul(nlo(n_q[p][i]), cam[i]));
        pch_q[p][i] <= PW'(smul(nhi(n_q[p][i]), cam[i]));
        ncam_q[p][i] <= (SW'(pch_q[p][i]) <<< NH) + SW'(pcl_q[p][i]);
      end
      ncx_q[p] <= (SW'(pxh_q[p]) <<< NH) + SW'(pxl_q[p]);
      ncz_q[p] <= (SW'(pzh_q[p]) <<< NH) + SW'(pzl_q[p]);
      sa_q[p] <= ncx_q[p] * LEN_Q + ncz_q[p] * LEN_Q
               - SW'(n_q[p][0]) * HALF_Q - SW'(n_q[p][2]) * HALF_Q + e_q[p];
      sb_q[p] <= ncam_q[p][0] + ncam_q[p][1] + ncam_q[p][2];
    end

    visible_o <= !(side_cull || nf_q[3]);
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

typedef logic signed [127:0] wide_t;

class chunk_visibility_board;
  logic [62:0] regs [8];
  bit          visible_q [$];
  int          mismatches;
  int          strays;

  function new();
    regs[fbc_pkg::REG_CAM_POS] = 63'd0;
    regs[fbc_pkg::REG_FRONT]   = 63'd49152;
    regs[fbc_pkg::REG_UP]      = 63'd1073741824;
    regs[fbc_pkg::REG_RIGHT]   = 63'd16384;
    regs[fbc_pkg::REG_NEAR]    = 63'd26;
    regs[fbc_pkg::REG_FAR]     = 63'd256000;
    regs[fbc_pkg::REG_TAN]     = 63'd6786;
    regs[fbc_pkg::REG_ASPECT]  = 63'd4096;
    mismatches = 0;
    strays = 0;
  endfunction

  function void write_reg(int idx, logic [62:0] val);
    int w [8] = '{63, 48, 48, 48, 24, 24, 16, 16};
    if (idx < 8) regs[idx] = 63'(val & ((64'h1 << w[idx]) - 1));
  endfunction

  function void unpack(logic [62:0] r, int bits, output wide_t v [3]);
    wide_t t;
    for (int k = 0; k < 3; k++) begin
      t = wide_t'(r >> (k * bits));
      t = t <<< (128 - bits);
      v[k] = t >>> (128 - bits);
    end
  endfunction

  function wide_t dot(wide_t a [3], wide_t b [3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function void cross3(wide_t a [3], wide_t b [3], output wide_t r [3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Box is culled when all eight corners fall behind one plane.
  function bit chunk_visible(logic signed [15:0] cx, logic signed [15:0] cz);
    wide_t cam [3], fr [3], up [3], rt [3], lo [3], hi [3];
    wide_t d [8][3], n [4][3], a [3], b [3], crn [3];
    wide_t ha, tq, nd, fd;
    bit culled;
    int behind, bn, bf;
    unpack(regs[fbc_pkg::REG_CAM_POS], 21, cam);
    unpack(regs[fbc_pkg::REG_FRONT], 16, fr);
    unpack(regs[fbc_pkg::REG_UP], 16, up);
    unpack(regs[fbc_pkg::REG_RIGHT], 16, rt);
    nd = wide_t'(regs[fbc_pkg::REG_NEAR]);
    fd = wide_t'(regs[fbc_pkg::REG_FAR]);
    tq = wide_t'(regs[fbc_pkg::REG_TAN]);
    ha = (tq * wide_t'(regs[fbc_pkg::REG_ASPECT]) + 2048) >>> 12;
    lo[0] = wide_t'(cx) * fbc_pkg::LEN_Q - fbc_pkg::HALF_Q;
    lo[1] = 0;
    lo[2] = wide_t'(cz) * fbc_pkg::LEN_Q - fbc_pkg::HALF_Q;
    hi[0] = lo[0] + fbc_pkg::LEN_Q;
    hi[1] = fbc_pkg::HGT_Q;
    hi[2] = lo[2] + fbc_pkg::LEN_Q;
    for (int c = 0; c < 8; c++) begin
      d[c][0] = (c[2] ? hi[0] : lo[0]) - cam[0];
      d[c][1] = (c[1] ? hi[1] : lo[1]) - cam[1];
      d[c][2] = (c[0] ? hi[2] : lo[2]) - cam[2];
    end
    for (int i = 0; i < 3; i++) a[i] = fr[i] * 16384 - rt[i] * ha;
    cross3(a, up, n[0]);
    for (int i = 0; i < 3; i++) a[i] = fr[i] * 16384 + rt[i] * ha;
    cross3(up, a, n[1]);
    for (int i = 0; i < 3; i++) a[i] = fr[i] * 16384 - up[i] * tq;
    cross3(rt, a, n[2]);
    for (int i = 0; i < 3; i++) a[i] = fr[i] * 16384 + up[i] * tq;
    cross3(a, rt, n[3]);
    culled = 0;
    if (fd > 0) begin
      for (int p = 0; p < 4; p++) begin
        behind = 0;
        for (int c = 0; c < 8; c++) begin
          crn = d[c];
          if (dot(n[p], crn) < 0) behind++;
        end
        if (behind == 8) culled = 1;
      end
    end
    bn = 0;
    bf = 0;
    for (int c = 0; c < 8; c++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = d[c][i] * 16384 - nd * fr[i];
        b[i] = d[c][i] * 16384 - fd * fr[i];
      end
      if (dot(a, fr) < 0) bn++;
      if (dot(b, fr) > 0) bf++;
    end
    if (bn == 8 || bf == 8) culled = 1;
    return !culled;
  endfunction

  function void note_chunk(logic signed [15:0] cx, logic signed [15:0] cz);
    visible_q.push_back(chunk_visible(cx, cz));
  endfunction

  function void check_visible(bit got);
    bit want;
    if (visible_q.size() == 0) begin
      strays++;
      $display("unexpected result transfer, visible=%0d", got);
      return;
    end
    want = visible_q.pop_front();
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("visible mismatch: expected %0d, got %0d", want, got);
    end
  endfunction
endclass

module tb_top;
  import fbc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int FIRST_UNUSED_REG = 8;
  localparam int PIPE_LATENCY = 8;

  logic                     clk_i = 0;
  logic                     rst_ni = 0;
  logic                     start_i = 0;
  logic                     busy_o;
  logic signed [15:0]       chunk_x_i = 0;
  logic signed [15:0]       chunk_z_i = 0;
  logic                     valid_o;
  logic                     visible_o;
  logic                     cfg_we_i = 0;
  logic [IDX_W-1:0]         cfg_idx_i = '0;
  logic [CFG_W-1:0]         cfg_wdata_i = '0;

  chunk_visibility_board board = new();
  int cycles = 0;

  frustum_box_cull_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (start_i && !busy_o) board.note_chunk(chunk_x_i, chunk_z_i);
      if (valid_o) board.check_visible(visible_o);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [62:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= IDX_W'(idx);
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_chunk(logic [15:0] cx, logic [15:0] cz, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i   <= 1'b1;
    chunk_x_i <= cx;
    chunk_z_i <= cz;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Lets the pipeline empty so register writes never overlap a chunk in flight.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (board.visible_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_vec();
    logic [15:0] c [3];
    int ax;
    c = '{16'd0, 16'd0, 16'd0};
    if ($urandom_range(3) == 0) begin
      return 48'({$urandom, $urandom});
    end
    ax = $urandom_range(2);
    c[ax] = $urandom_range(1) ? 16'd16384 : -16'sd16384;
    return {c[2], c[1], c[0]};
  endfunction

  // Random bits above a register's width check that the block masks them.
  function automatic logic [62:0] junk_above(int w, logic [62:0] v);
    logic [62:0] g;
    g = 63'({$urandom, $urandom});
    return (g << w) | v;
  endfunction

  task automatic load_camera(int kind);
    logic [62:0] v [8];
    for (int i = 0; i < 8; i++) v[i] = '0;
    if (kind == 1) begin
      for (int i = 0; i < 8; i++) v[i] = '1;
    end else if (kind == 2) begin
      v[REG_CAM_POS] = 63'({$urandom, $urandom});
      v[REG_FRONT]   = junk_above(48, 63'(rand_vec()));
      v[REG_UP]      = junk_above(48, 63'(rand_vec()));
      v[REG_RIGHT]   = junk_above(48, 63'(rand_vec()));
      v[REG_NEAR]    = junk_above(24, 63'($urandom_range(0, 2000)));
      v[REG_FAR]     = junk_above(24, 63'($urandom_range(0, 16777215)));
      v[REG_TAN]     = junk_above(16, 63'($urandom_range(0, 65535)));
      v[REG_ASPECT]  = junk_above(16, 63'($urandom_range(0, 65535)));
    end else if (kind == 3) begin
      v[REG_CAM_POS] = {21'($urandom_range(0, 40000)), 21'($urandom_range(0, 60000)),
                        21'($urandom_range(0, 40000))};
      v[REG_FRONT]   = 63'(rand_vec());
      v[REG_UP]      = 63'(rand_vec());
      v[REG_RIGHT]   = 63'(rand_vec());
      v[REG_NEAR]    = 63'($urandom_range(0, 300));
      v[REG_FAR]     = 63'($urandom_range(1000, 300000));
      v[REG_TAN]     = 63'($urandom_range(2000, 20000));
      v[REG_ASPECT]  = 63'($urandom_range(2048, 8192));
    end
    for (int i = 0; i < 8; i++) write_reg(i, v[i]);
  endtask

  task automatic random_chunks(int count, int idle_pct);
    logic [62:0] cam;
    logic signed [20:0] px, pz;
    int cx, cz;
    cam = board.regs[REG_CAM_POS];
    px = cam[20:0];
    pz = cam[62:42];
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) < 7) begin
        cx = int'(px >>> 12) + int'($urandom_range(0, 40)) - 20;
        cz = int'(pz >>> 12) + int'($urandom_range(0, 40)) - 20;
        send_chunk(16'(cx), 16'(cz), idle_pct);
      end else begin
        send_chunk(16'($urandom), 16'($urandom), idle_pct);
      end
    end
  endtask

  initial begin
    int idle_modes [4];
    idle_modes = '{0, 49, 0, 17};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed chunks against the reset camera.
    send_chunk(16'h8000, 16'h8000, 0);
    send_chunk(16'h7fff, 16'h7fff, 0);
    send_chunk(16'h8000, 16'h7fff, 0);
    send_chunk(16'h0000, 16'h0000, 0);
    send_chunk(16'hffff, 16'h0000, 0);
    send_chunk(16'h0001, 16'hffff, 0);
    send_chunk(16'hfff0, 16'h0002, 0);
    send_chunk(16'h0010, 16'hfffe, 0);
    drain();
    // Zero far distance: side planes stop culling.
    write_reg(REG_FAR, 63'd0);
    send_chunk(16'h0000, 16'h0000, 0);
    send_chunk(16'hfff0, 16'h0005, 0);
    send_chunk(16'h7fff, 16'h8000, 0);
    drain();
    // Degenerate all-zero camera, and writes to indexes past the list.
    load_camera(0);
    write_reg(FIRST_UNUSED_REG + $urandom_range(0, 7), 63'({$urandom, $urandom}));
    write_reg(15, '1);
    send_chunk(16'h0000, 16'h0000, 0);
    send_chunk(16'h8000, 16'h7fff, 0);
    send_chunk(16'h1234, 16'hedcb, 0);
    drain();

    for (int s = 0; s < 8; s++) begin
      load_camera(s == 0 ? 1 : (s == 5 ? 0 : (s % 3 == 0 ? 2 : 3)));
      random_chunks(105, idle_modes[s % 4]);
      drain();
    end

    if (board.mismatches == 0 && board.strays == 0 && board.visible_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
